@@ src/assert_macros.svh @@
// shared assertion macros, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a rising edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_AT(label, !(expr), msg)

`endif

@@ src/chm_pkg.sv @@
package chm_pkg;

	localparam int LUMA_WIDTH      = 32;
	localparam int COUNT_WIDTH     = 24;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 8;

	// register indexes on the config port
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WHITE_LEVEL   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLACK_LEVEL   = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPOSURE_HOLD = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREEZE_HOLD   = 2'd3;

	localparam logic [CFG_DATA_WIDTH-1:0] WHITE_LEVEL_RST   = 8'd240;
	localparam logic [CFG_DATA_WIDTH-1:0] BLACK_LEVEL_RST   = 8'd12;
	localparam logic [CFG_DATA_WIDTH-1:0] EXPOSURE_HOLD_RST = 8'd5;
	localparam logic [CFG_DATA_WIDTH-1:0] FREEZE_HOLD_RST   = 8'd8;

	localparam logic [LUMA_WIDTH-1:0] MEAN_NO_STATS = 32'd128;

	// changed*1000 < 2*count is the same test as changed*500 < count
	localparam int CHANGE_SCALE = 1000;
	localparam int CHANGE_MIN   = 2;
	localparam int CHANGE_RATIO = CHANGE_SCALE / CHANGE_MIN;
	localparam int PROD_WIDTH   = COUNT_WIDTH + $clog2(CHANGE_RATIO);

	localparam int DIV_CNT_WIDTH = $clog2(LUMA_WIDTH);

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DIV,
		FSM_DONE
	} fsm_t;

	typedef enum logic [1:0] {
		HEALTH_OK       = 2'd0,
		HEALTH_WHITEOUT = 2'd1,
		HEALTH_BLACKOUT = 2'd2,
		HEALTH_FROZEN   = 2'd3
	} cam_state_t;

	typedef struct packed {
		logic [LUMA_WIDTH-1:0]  luma_total;
		logic [COUNT_WIDTH-1:0] pixel_count;
		logic [COUNT_WIDTH-1:0] changed_pixels;
	} in_req_t;

	typedef struct packed {
		cam_state_t camera_state;
		logic       state_changed;
	} out_req_t;

endpackage

@@ src/camera_health_monitor.sv @@
// camera health monitor
// one request per video frame enters on in_valid/in_stall/in_data: luma sum,
// pixel count and changed-pixel count. one request leaves per input on
// out_valid/out_stall/out_data: camera state (ok, whiteout, blackout, frozen)
// and a flag set when that state differs from the one before.
// thresholds and holds are written on cfg_write/cfg_index/cfg_data; the user
// must do so while idle, unenforced by the block; they take effect next frame.
// the mean luma comes from a restoring divider that settles one quotient bit
// per clock. a frame goes through the divide state and then the commit state,
// and a new frame is taken only after the last one is committed.
// in_stall is high from acceptance until the result is committed; a finished
// result sits in the output register, so the next frame may be accepted
// while the receiver still stalls. a stalled result waits in the commit
// cycle only if the output register is still full.
// reset (arst_n low) returns the state to ok, clears both streaks and loads
// the register defaults (white 240, black 12, exposure hold 5, freeze hold 8).
`include "assert_macros.svh"

module camera_health_monitor #(
	parameter int STREAK_WIDTH = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [chm_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [chm_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  chm_pkg::in_req_t                        in_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output chm_pkg::out_req_t                       out_data
);

	localparam int LW  = chm_pkg::LUMA_WIDTH;
	localparam int CW  = chm_pkg::COUNT_WIDTH;
	localparam int PW  = chm_pkg::PROD_WIDTH;
	localparam int DCW = chm_pkg::DIV_CNT_WIDTH;
	// width that holds both a streak and an 8-bit hold for the compare
	localparam int CMP_W = (STREAK_WIDTH > chm_pkg::CFG_DATA_WIDTH) ?
		STREAK_WIDTH : chm_pkg::CFG_DATA_WIDTH;
	localparam logic [STREAK_WIDTH-1:0] STREAK_MAX = '1;
	localparam logic [DCW-1:0] DIV_LAST = DCW'(LW - 1);

	// configuration registers
	logic [chm_pkg::CFG_DATA_WIDTH-1:0] white_level_q;
	logic [chm_pkg::CFG_DATA_WIDTH-1:0] black_level_q;
	logic [chm_pkg::CFG_DATA_WIDTH-1:0] exposure_hold_q;
	logic [chm_pkg::CFG_DATA_WIDTH-1:0] freeze_hold_q;

	// control and health state
	chm_pkg::fsm_t       fsm_q, fsm_d;
	logic [DCW-1:0]      div_cnt_q;
	chm_pkg::cam_state_t cur_state_q;
	logic [STREAK_WIDTH-1:0] exposure_q, freeze_q;
	logic                out_valid_q;

	// divider datapath: dividend shifts out at the top, quotient in at the bottom
	logic [LW-1:0]       dq_q;
	logic [CW-1:0]       rem_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       prod_q;
	chm_pkg::out_req_t   out_data_q;

	logic                accept, commit;
	logic [CW:0]         trial, trial_diff;
	logic                trial_ge;

	logic [LW-1:0]       mean;
	logic                over, under, low_change;
	logic [STREAK_WIDTH-1:0] exposure_inc, freeze_inc, exposure_d, freeze_d;
	chm_pkg::cam_state_t next_state;

	assign accept = in_valid && !in_stall;

	// config writes, made only while idle by contract; the block does not check it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_level_q   <= chm_pkg::WHITE_LEVEL_RST;
			black_level_q   <= chm_pkg::BLACK_LEVEL_RST;
			exposure_hold_q <= chm_pkg::EXPOSURE_HOLD_RST;
			freeze_hold_q   <= chm_pkg::FREEZE_HOLD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				chm_pkg::REG_WHITE_LEVEL:   white_level_q   <= cfg_data;
				chm_pkg::REG_BLACK_LEVEL:   black_level_q   <= cfg_data;
				chm_pkg::REG_EXPOSURE_HOLD: exposure_hold_q <= cfg_data;
				chm_pkg::REG_FREEZE_HOLD:   freeze_hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			chm_pkg::FSM_IDLE: if (accept) fsm_d = chm_pkg::FSM_DIV;
			chm_pkg::FSM_DIV:  if (div_cnt_q == DIV_LAST) fsm_d = chm_pkg::FSM_DONE;
			chm_pkg::FSM_DONE: if (commit) fsm_d = chm_pkg::FSM_IDLE;
			default:           fsm_d = chm_pkg::FSM_IDLE;
		endcase
	end

	// sequencer outputs: busy from accept to commit; commit needs a free
	// output register or one being drained this cycle
	always_comb begin
		in_stall = (fsm_q != chm_pkg::FSM_IDLE);
		commit   = (fsm_q == chm_pkg::FSM_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= chm_pkg::FSM_IDLE;
			div_cnt_q <= '0;
		end else begin
			fsm_q <= fsm_d;
			if (accept) begin
				div_cnt_q <= '0;
			end else if (fsm_q == chm_pkg::FSM_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// one restoring divide step: bring down the next dividend bit, subtract
	// the count when it fits
	always_comb begin
		trial      = {rem_q, dq_q[LW-1]};
		trial_diff = trial - {1'b0, count_q};
		trial_ge   = (trial >= {1'b0, count_q});
	end

	// datapath registers carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			dq_q    <= in_data.luma_total;
			rem_q   <= '0;
			count_q <= in_data.pixel_count;
			// constant multiply for the low-change test
			prod_q  <= PW'(in_data.changed_pixels) * PW'(chm_pkg::CHANGE_RATIO);
		end else if (fsm_q == chm_pkg::FSM_DIV) begin
			dq_q  <= {dq_q[LW-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
		end
	end

	// frame classification and next health state, evaluated in the commit cycle
	always_comb begin
		mean       = (count_q == '0) ? chm_pkg::MEAN_NO_STATS : dq_q;
		over       = mean > LW'(white_level_q);
		under      = mean < LW'(black_level_q);
		// a zero product means no changed pixels at all
		low_change = (prod_q == '0) || (prod_q < PW'(count_q));

		exposure_inc = (exposure_q == STREAK_MAX) ? exposure_q : exposure_q + 1'b1;
		freeze_inc   = (freeze_q == STREAK_MAX) ? freeze_q : freeze_q + 1'b1;

		if (over || under) begin
			exposure_d = exposure_inc;
			freeze_d   = '0;
		end else if (low_change) begin
			exposure_d = '0;
			freeze_d   = freeze_inc;
		end else begin
			exposure_d = '0;
			freeze_d   = '0;
		end

		// freeze wins over exposure; a zero hold always fires
		if (CMP_W'(freeze_d) >= CMP_W'(freeze_hold_q)) begin
			next_state = chm_pkg::HEALTH_FROZEN;
		end else if (CMP_W'(exposure_d) >= CMP_W'(exposure_hold_q)) begin
			next_state = over ? chm_pkg::HEALTH_WHITEOUT : chm_pkg::HEALTH_BLACKOUT;
		end else if ((exposure_d == '0) && (freeze_d == '0)) begin
			next_state = chm_pkg::HEALTH_OK;
		end else begin
			next_state = cur_state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q <= chm_pkg::HEALTH_OK;
			exposure_q  <= '0;
			freeze_q    <= '0;
		end else if (commit) begin
			cur_state_q <= next_state;
			exposure_q  <= exposure_d;
			freeze_q    <= freeze_d;
		end
	end

	// output register: holds a result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q.camera_state  <= next_state;
			out_data_q.state_changed <= (next_state != cur_state_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// an accepted frame always starts the divider
	`ASSERT_AT(a_accept_starts_div, accept |=> (fsm_q == chm_pkg::FSM_DIV),
		"accepted frame did not start the divider")
	// a fresh result only appears out of the commit cycle
	`ASSERT_AT(a_result_from_commit, $rose(out_valid_q) |-> $past(fsm_q == chm_pkg::FSM_DONE),
		"result appeared without a commit")
	// the pending result always shows the current health state
	`ASSERT_NEVER(a_out_matches_state, out_valid_q && (out_data_q.camera_state != cur_state_q),
		"pending result disagrees with the stored state")

endmodule

@@ bench/tb_camera_health_monitor.sv @@
module tb_camera_health_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LW = chm_pkg::LUMA_WIDTH;
	localparam int CW = chm_pkg::COUNT_WIDTH;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 11;
	// settling time; a frame passes through the divider and then the commit stage
	localparam int SETTLE_CYCLES  = 40;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int MAX_SHOWN      = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_FRAMES   = 6;
	// long enough to carry a streak past its 8-bit ceiling
	localparam int SATURATION_RUN = 258;
	localparam int RUN_CAP        = 16;

	localparam logic [7:0]    STREAK_MAX = 8'hFF;
	localparam logic [LW-1:0] LUMA_MAX   = 32'hFF00_0000;
	// 255 * (2^24 - 1): mean of exactly 255 at the largest pixel count
	localparam logic [LW-1:0] LUMA_255_FULL = 32'hFEFF_FF01;
	localparam logic [CW-1:0] COUNT_FULL    = 24'hFF_FFFF;

	// frame flavors for the stimulus generator
	typedef enum {
		FR_BRIGHT,
		FR_DARK,
		FR_STEADY,
		FR_STILL,
		FR_NOISE
	} frame_kind_t;

	// dut ports, every input known from time zero
	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_write = 1'b0;
	logic [chm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = chm_pkg::REG_WHITE_LEVEL;
	logic [chm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
	logic                                in_valid  = 1'b0;
	logic                                in_stall;
	chm_pkg::in_req_t                    in_data   = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	chm_pkg::out_req_t                   out_data;

	// predictor copy of the registers, loaded with the reset defaults
	logic [7:0] white_lvl         = chm_pkg::WHITE_LEVEL_RST;
	logic [7:0] black_lvl         = chm_pkg::BLACK_LEVEL_RST;
	logic [7:0] exposure_hold_lvl = chm_pkg::EXPOSURE_HOLD_RST;
	logic [7:0] freeze_hold_lvl   = chm_pkg::FREEZE_HOLD_RST;

	// predictor copy of the health state
	chm_pkg::cam_state_t cam_state    = chm_pkg::HEALTH_OK;
	logic [7:0]          exposure_run = '0;
	logic [7:0]          freeze_run   = '0;

	// health reports predicted for accepted frames, oldest first
	chm_pkg::out_req_t predicted_reports[$];
	int unsigned bad_reports = 0;

	// idling control for sender and receiver, and the watchdog cycle count
	bit          gaps_on       = 1'b1;
	int unsigned hold_request  = 0;
	int unsigned hold_left     = 0;
	int unsigned stall_left    = 0;
	int unsigned cycle_count   = 0;

	camera_health_monitor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// classify one frame, advance the streaks and return the health report
	function automatic chm_pkg::out_req_t judge_frame(chm_pkg::in_req_t f);
		logic [LW-1:0]       mean;
		logic [47:0]         changed_scaled;
		logic [47:0]         count_scaled;
		logic                over;
		logic                under;
		chm_pkg::cam_state_t prev_state;
		chm_pkg::cam_state_t next_state;
		chm_pkg::out_req_t   rpt;
		// no statistics means a mid-gray mean
		mean = (f.pixel_count != '0) ? f.luma_total / LW'(f.pixel_count)
			: chm_pkg::MEAN_NO_STATS;
		over  = mean > LW'(white_lvl);
		under = mean < LW'(black_lvl);
		changed_scaled = 48'(f.changed_pixels) * 48'(chm_pkg::CHANGE_SCALE);
		count_scaled   = 48'(f.pixel_count) * 48'(chm_pkg::CHANGE_MIN);
		prev_state = cam_state;

		// exposure wins over low change; both streaks stop at their ceiling
		if (over || under) begin
			exposure_run = (exposure_run == STREAK_MAX) ? STREAK_MAX : exposure_run + 8'd1;
			freeze_run   = '0;
		end else if (f.changed_pixels == '0 || changed_scaled < count_scaled) begin
			freeze_run   = (freeze_run == STREAK_MAX) ? STREAK_MAX : freeze_run + 8'd1;
			exposure_run = '0;
		end else begin
			exposure_run = '0;
			freeze_run   = '0;
		end

		// a zero hold always fires
		if (freeze_run >= freeze_hold_lvl)
			next_state = chm_pkg::HEALTH_FROZEN;
		else if (exposure_run >= exposure_hold_lvl)
			next_state = over ? chm_pkg::HEALTH_WHITEOUT : chm_pkg::HEALTH_BLACKOUT;
		else if (exposure_run == '0 && freeze_run == '0)
			next_state = chm_pkg::HEALTH_OK;
		else
			next_state = prev_state;

		cam_state = next_state;
		rpt.camera_state  = next_state;
		rpt.state_changed = (next_state != prev_state);
		return rpt;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(30, 4);
		return $urandom_range(150, 31);
	endfunction

	// build a frame whose mean and change ratio land in the wanted class
	// under the current levels; mostly small pixel counts, some full size
	function automatic chm_pkg::in_req_t make_frame(frame_kind_t kind);
		chm_pkg::in_req_t       f;
		int unsigned            pick;
		int unsigned            mean_lo;
		int unsigned            mean_hi;
		longint unsigned        mean;
		longint unsigned        total;
		logic [CW-1:0]          count;
		logic [CW-1:0]          change_floor;
		pick = $urandom_range(9);
		if (pick < 6)
			count = CW'($urandom_range(4095, 1));
		else if (pick < 9)
			count = CW'($urandom_range(32'(COUNT_FULL), 1));
		else
			count = COUNT_FULL;

		case (kind)
			FR_BRIGHT: begin
				mean_lo = 32'(white_lvl) + 32'd1;
				// a white level of 255 needs a full-width mean to be exceeded
				mean_hi = (mean_lo > 255) ? mean_lo + 32'd4000 : 32'd255;
			end
			FR_DARK: begin
				mean_lo = 0;
				mean_hi = (black_lvl == '0) ? 32'd0 : 32'(black_lvl) - 32'd1;
			end
			default: begin
				if (black_lvl <= white_lvl) begin
					mean_lo = 32'(black_lvl);
					mean_hi = 32'(white_lvl);
				end else begin
					mean_lo = 0;
					mean_hi = 255;
				end
			end
		endcase
		mean  = 64'($urandom_range(mean_hi, mean_lo));
		total = mean * 64'(count) + 64'($urandom_range(32'(count) - 32'd1));
		if (total > 64'(LUMA_MAX))
			total = 64'(LUMA_MAX);
		f.luma_total  = LW'(total);
		f.pixel_count = count;

		// smallest change count that is not a low-change frame
		change_floor = CW'((32'(count) + 32'(chm_pkg::CHANGE_RATIO) - 32'd1)
			/ 32'(chm_pkg::CHANGE_RATIO));
		if (kind == FR_STILL)
			f.changed_pixels = ($urandom_range(3) == 0) ? '0
				: CW'($urandom_range((32'(count) - 32'd1) / 32'(chm_pkg::CHANGE_RATIO)));
		else if ($urandom_range(4) == 0)
			f.changed_pixels = CW'($urandom());
		else
			f.changed_pixels = CW'($urandom_range(32'(count), 32'(change_floor)));

		// noise: anything the fields allow
		if (kind == FR_NOISE) begin
			f.luma_total     = $urandom_range(LUMA_MAX);
			f.pixel_count    = ($urandom_range(3) == 0) ? '0 : CW'($urandom());
			f.changed_pixels = ($urandom_range(3) == 0) ? '0
				: CW'($urandom() >> $urandom_range(24));
		end
		return f;
	endfunction

	// offer one frame request and wait for the block to take it
	// valid stays high afterwards so back-to-back frames need no extra edge
	task automatic send_frame(input chm_pkg::in_req_t frame);
		int unsigned idle;
		idle = gaps_on ? gap_len() : 0;
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= frame;
		do
			@(posedge clk);
		while (in_stall);
		predicted_reports.push_back(judge_frame(frame));
	endtask

	// stop sending and let every predicted report come back
	task automatic wait_for_reports();
		in_valid <= 1'b0;
		while (predicted_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller lowers the write enable
	task automatic put_reg(input logic [chm_pkg::CFG_INDEX_WIDTH-1:0] idx,
		input logic [chm_pkg::CFG_DATA_WIDTH-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			chm_pkg::REG_WHITE_LEVEL:   white_lvl         = val;
			chm_pkg::REG_BLACK_LEVEL:   black_lvl         = val;
			chm_pkg::REG_EXPOSURE_HOLD: exposure_hold_lvl = val;
			chm_pkg::REG_FREEZE_HOLD:   freeze_hold_lvl   = val;
			default: ;
		endcase
	endtask

	// reprogram all four registers once the block has gone idle
	task automatic set_levels(input logic [chm_pkg::CFG_DATA_WIDTH-1:0] white,
		input logic [chm_pkg::CFG_DATA_WIDTH-1:0] black,
		input logic [chm_pkg::CFG_DATA_WIDTH-1:0] exp_hold,
		input logic [chm_pkg::CFG_DATA_WIDTH-1:0] frz_hold);
		wait_for_reports();
		put_reg(chm_pkg::REG_WHITE_LEVEL, white);
		put_reg(chm_pkg::REG_BLACK_LEVEL, black);
		put_reg(chm_pkg::REG_EXPOSURE_HOLD, exp_hold);
		put_reg(chm_pkg::REG_FREEZE_HOLD, frz_hold);
		cfg_write <= 1'b0;
	endtask

	// field extremes and state walk under the reset defaults
	task automatic test_directed_defaults();
		// no statistics, nothing changed: counts as a low-change frame
		send_frame('{32'd0, 24'd0, 24'd0});
		// no statistics but lots of change: mid-gray and active, state stays ok
		send_frame('{LUMA_MAX, 24'd0, COUNT_FULL});
		// full-width mean far above any 8-bit level
		send_frame('{LUMA_MAX, 24'd1, 24'd1});
		// black frame at the largest count keeps the exposure streak going
		send_frame('{32'd0, COUNT_FULL, COUNT_FULL});
		// mean of 255 at the largest count: whiteout once the hold is met
		repeat (3) send_frame('{LUMA_255_FULL, COUNT_FULL, COUNT_FULL});
		// dark frame with the streak past its hold flips to blackout
		send_frame('{32'd0, 24'd1000, 24'd1000});
		// means exactly on the white and the black level are normal
		send_frame('{32'd240000, 24'd1000, 24'd2});
		send_frame('{32'd12000, 24'd1000, 24'd2});
		// one pixel short of the change threshold, held until frozen
		repeat (8) send_frame('{32'd128000, 24'd1000, 24'd1});
	endtask

	// a hold of zero fires on every frame
	task automatic test_zero_holds();
		set_levels(chm_pkg::WHITE_LEVEL_RST, chm_pkg::BLACK_LEVEL_RST,
			chm_pkg::EXPOSURE_HOLD_RST, 8'd0);
		send_frame('{32'd128000, 24'd1000, 24'd500});
		send_frame('{LUMA_MAX, 24'd1, 24'd1});
		// exposure hold zero, levels wide open: normal frames read as blackout
		set_levels(8'd255, 8'd0, 8'd0, 8'd255);
		send_frame('{32'd128000, 24'd1000, 24'd500});
		// only a full-width mean can beat a white level of 255
		send_frame('{LUMA_MAX, 24'd1, 24'd1});
		send_frame('{32'd0, 24'd0, 24'd0});
	endtask

	// receiver holds off for a long stretch while frames keep coming,
	// so the result register and the divider fill and in_stall rises
	task automatic test_backpressure();
		set_levels(chm_pkg::WHITE_LEVEL_RST, chm_pkg::BLACK_LEVEL_RST,
			chm_pkg::EXPOSURE_HOLD_RST, chm_pkg::FREEZE_HOLD_RST);
		gaps_on = 1'b0;
		hold_request = 400;
		repeat (10) send_frame(make_frame(frame_kind_t'($urandom_range(4))));
		// sender pauses until every report is back
		wait_for_reports();
		gaps_on = 1'b1;
	endtask

	// phases of fixed and random settings, mostly runs of one frame class so the
	// holds are reached, with noise frames mixed in
	task automatic test_random_phases();
		int unsigned sent;
		int unsigned r;
		int unsigned run_len;
		int unsigned run_max;
		frame_kind_t kind;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_levels(chm_pkg::WHITE_LEVEL_RST, chm_pkg::BLACK_LEVEL_RST,
					chm_pkg::EXPOSURE_HOLD_RST, chm_pkg::FREEZE_HOLD_RST);
				1: set_levels(8'd255, 8'd0, 8'd0, 8'd0);
				// white below black: every mean is an anomaly
				2: set_levels(8'd0, 8'd255, 8'd3, 8'd2);
				3: set_levels(8'd255, 8'd0, 8'd255, 8'd255);
				4: set_levels(8'd128, 8'd128, 8'd1, 8'd1);
				default: set_levels(8'($urandom_range(255, 100)), 8'($urandom_range(100)),
					8'($urandom_range(10)), 8'($urandom_range(10)));
			endcase
			// every fourth phase runs with no idling at all
			gaps_on = (ph % 4 != 3);
			sent = 0;
			while (sent < PHASE_FRAMES) begin
				r = $urandom_range(99);
				kind = (r < 25) ? FR_BRIGHT : (r < 45) ? FR_DARK : (r < 65) ? FR_STEADY
					: (r < 90) ? FR_STILL : FR_NOISE;
				run_max = ((kind == FR_STILL) ? freeze_hold_lvl : exposure_hold_lvl) + 2;
				if (run_max > RUN_CAP)
					run_max = RUN_CAP;
				if (kind == FR_NOISE)
					run_max = 3;
				run_len = $urandom_range(run_max, 1);
				// bright runs get dark frames mixed in to swap whiteout and blackout
				repeat (run_len)
					send_frame(make_frame((kind == FR_BRIGHT && $urandom_range(4) == 0)
						? FR_DARK : kind));
				sent += run_len;
			end
		end
		gaps_on = 1'b1;
	endtask

	// drive both streaks into their ceiling with the holds at maximum
	task automatic test_streak_saturation();
		set_levels(8'd200, 8'd50, 8'hFF, 8'hFF);
		gaps_on = 1'b0;
		// exposure streak stops at 255 and the hold keeps firing past it
		repeat (SATURATION_RUN)
			send_frame(make_frame(($urandom_range(3) == 0) ? FR_DARK : FR_BRIGHT));
		send_frame(make_frame(FR_STEADY));
		// same for the freeze streak
		repeat (SATURATION_RUN) send_frame(make_frame(FR_STILL));
		send_frame(make_frame(FR_BRIGHT));
		wait_for_reports();
		gaps_on = 1'b1;
	endtask

	// compare one report request with the oldest prediction
	task automatic check_report(input chm_pkg::out_req_t got);
		chm_pkg::out_req_t want;
		if (predicted_reports.size() == 0) begin
			bad_reports++;
			if (bad_reports <= MAX_SHOWN)
				$display("unexpected report: state %0d changed %0b",
					got.camera_state, got.state_changed);
			return;
		end
		want = predicted_reports.pop_front();
		if (got.camera_state !== want.camera_state
			|| got.state_changed !== want.state_changed) begin
			bad_reports++;
			if (bad_reports <= MAX_SHOWN)
				$display("report mismatch: state exp %0d got %0d, changed exp %0b got %0b",
					want.camera_state, got.camera_state,
					want.state_changed, got.state_changed);
		end
	endtask

	// receiver: checks reports and decides out_stall for the next edge;
	// a long hold-off is counted down here, random stalls otherwise while gaps are on
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_report(out_data);
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_left == 0 && gaps_on && $urandom_range(3) == 0)
				stall_left = gap_len();
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// cycle watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_zero_holds();
		test_backpressure();
		test_random_phases();
		test_streak_saturation();

		// nothing may remain outstanding before the verdict
		wait_for_reports();
		if (bad_reports == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/chm_pkg.sv
src/camera_health_monitor.sv
bench/tb_camera_health_monitor.sv
